// ===== rtl/ejtre_pkg.sv =====
package ejtre_pkg;

    // Translation table geometry.
    localparam int TABLE_DEPTH = 24064;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam logic [15:0] TABLE_DEPTH_W = 16'(TABLE_DEPTH);

    // Code classification constants.
    localparam logic [15:0] CODE_HIGH_BITS  = 16'h8080;
    localparam logic [15:0] CODE_LOW_LIMIT  = 16'hA1A1;
    localparam logic [15:0] CODE_HIGH_LIMIT = 16'hFF00;
    localparam logic [15:0] CODE_BASE       = 16'hA180;
    localparam logic [7:0]  PRINT_LOW       = 8'h20;
    localparam logic [7:0]  PRINT_END       = 8'h7F;
    localparam logic [15:0] TERMINATOR      = 16'h000A;

    // Item kinds on the input channel.
    localparam logic MODE_DATA  = 1'b0;
    localparam logic MODE_TABLE = 1'b1;

    // Run length classes.
    localparam logic [1:0] RUN_EMPTY = 2'd0;
    localparam logic [1:0] RUN_ONE   = 2'd1;
    localparam logic [1:0] RUN_MANY  = 2'd2;

    // Queue between the front and the back; depth is a power of two.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Most results one data byte can cause.
    localparam int MAX_RES = 3;

    typedef logic [FIFO_CNT_W-1:0] fifo_cnt_t;
    typedef logic [FIFO_CNT_W:0]   fifo_occ_t;
    typedef logic [FIFO_PTR_W-1:0] fifo_ptr_t;

    // One classified data byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        end_of_data;
        logic        pair_ok;
        logic [15:0] pair_char;
    } ejtre_entry_t;

endpackage

// ===== rtl/ejtre_front.sv =====
module ejtre_front import ejtre_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_mode,
    input  logic [7:0]   s_data_byte,
    input  logic         s_end_of_data,
    input  logic [14:0]  s_table_index,
    input  logic [15:0]  s_table_value,
    input  fifo_cnt_t    q_count,
    output logic         q_push,
    output ejtre_entry_t q_entry
);

    logic [15:0] mem [TABLE_DEPTH];
    logic [15:0] rdata_reg;

    logic       s1_valid_reg;
    logic [7:0] prev_byte_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eod_reg;
    logic       s1_range_ok_reg;

    logic        accept;
    logic        data_acc;
    logic        tbl_wr;
    logic [15:0] code;
    logic [15:0] idx16;
    logic        range_ok;
    fifo_occ_t   occ;

    // A beat is taken only when the queue has room for it and the one in flight.
    assign occ      = {1'b0, q_count} + {{FIFO_CNT_W{1'b0}}, s1_valid_reg};
    assign s_ready  = (occ < fifo_occ_t'(FIFO_DEPTH));
    assign accept   = s_valid && s_ready;
    assign data_acc = accept && (s_mode == MODE_DATA);
    assign tbl_wr   = accept && (s_mode == MODE_TABLE) &&
                      ({1'b0, s_table_index} < TABLE_DEPTH_W);

    // Every data byte is paired with the byte before it; the back decides
    // whether that pair really was a lead byte and its partner.
    assign code     = {prev_byte_reg, s_data_byte};
    assign idx16    = code - CODE_BASE;
    assign range_ok = ((code & CODE_HIGH_BITS) == CODE_HIGH_BITS) &&
                      (code >= CODE_LOW_LIMIT) && (code < CODE_HIGH_LIMIT) &&
                      (idx16 < TABLE_DEPTH_W);

    // Translation table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (tbl_wr) begin
            mem[s_table_index[ADDR_W-1:0]] <= s_table_value;
        end
        if (data_acc && range_ok) begin
            rdata_reg <= mem[idx16[ADDR_W-1:0]];
        end
    end

    // Stage that waits for the table read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            prev_byte_reg <= 8'd0;
        end else begin
            s1_valid_reg <= data_acc;
            if (data_acc) begin
                prev_byte_reg <= s_data_byte;
            end
        end
        if (data_acc) begin
            s1_byte_reg     <= s_data_byte;
            s1_eod_reg      <= s_end_of_data;
            s1_range_ok_reg <= range_ok;
        end
    end

    assign q_push                = s1_valid_reg;
    assign q_entry.data_byte     = s1_byte_reg;
    assign q_entry.end_of_data   = s1_eod_reg;
    assign q_entry.pair_ok       = s1_range_ok_reg && (rdata_reg != 16'd0);
    assign q_entry.pair_char     = rdata_reg;

endmodule

// ===== rtl/ejtre_fifo.sv =====
module ejtre_fifo import ejtre_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  ejtre_entry_t push_entry,
    input  logic         pop,
    output logic         head_valid,
    output ejtre_entry_t head_entry,
    output fifo_cnt_t    count
);

    ejtre_entry_t entries_reg [FIFO_DEPTH];
    fifo_ptr_t    wr_ptr_reg;
    fifo_ptr_t    rd_ptr_reg;
    fifo_cnt_t    count_reg;
    fifo_cnt_t    count_next;

    assign head_valid = (count_reg != '0);
    assign head_entry = entries_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + fifo_cnt_t'(1);
        end else if (pop && !push) begin
            count_next = count_reg - fifo_cnt_t'(1);
        end
    end

    // Circular buffer with separate read and write pointers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + fifo_ptr_t'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + fifo_ptr_t'(1);
            end
            count_reg <= count_next;
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/ejtre_back.sv =====
module ejtre_back import ejtre_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         q_valid,
    input  ejtre_entry_t q_entry,
    output logic         q_pop,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [15:0]  m_code_unit,
    output logic         m_end_of_run,
    output logic         m_last
);

    // Run state.
    logic        lead_pending_reg, lead_pending_next;
    logic        skipping_reg, skipping_next;
    logic [15:0] held_char_reg, held_char_next;
    logic [1:0]  run_class_reg, run_class_next;

    // Result buffer; entry 0 is the beat on the output.
    logic [15:0] out_unit_reg [MAX_RES];
    logic        out_eor_reg [MAX_RES];
    logic [1:0]  out_cnt_reg;

    logic [15:0] res_unit [MAX_RES];
    logic        res_eor [MAX_RES];
    logic [1:0]  res_n;

    logic        do_add;
    logic        do_close;
    logic [15:0] add_val;
    logic        out_acc;

    assign m_valid      = (out_cnt_reg != 2'd0);
    assign m_code_unit  = out_unit_reg[0];
    assign m_end_of_run = out_eor_reg[0];
    assign m_last       = (out_cnt_reg == 2'd1);
    assign out_acc      = m_valid && m_ready;

    // Take the next byte once the buffer is empty or its last beat leaves.
    assign q_pop = q_valid && ((out_cnt_reg == 2'd0) || ((out_cnt_reg == 2'd1) && m_ready));

    // Classify the byte against the run state.
    always_comb begin
        lead_pending_next = lead_pending_reg;
        skipping_next     = skipping_reg;
        do_add            = 1'b0;
        do_close          = 1'b0;
        add_val           = q_entry.pair_char;
        if (lead_pending_reg) begin
            lead_pending_next = 1'b0;
            if (q_entry.pair_ok) begin
                do_add = 1'b1;
            end else begin
                do_close      = 1'b1;
                skipping_next = (q_entry.data_byte != 8'd0);
            end
        end else if (skipping_reg) begin
            if (q_entry.data_byte == 8'd0) begin
                skipping_next = 1'b0;
                do_close      = 1'b1;
            end
        end else if (q_entry.data_byte < PRINT_LOW) begin
            do_close = 1'b1;
        end else if (q_entry.data_byte < PRINT_END) begin
            do_add  = 1'b1;
            add_val = {8'd0, q_entry.data_byte};
        end else begin
            lead_pending_next = 1'b1;
        end
        if (q_entry.end_of_data) begin
            lead_pending_next = 1'b0;
            skipping_next     = 1'b0;
            do_close          = 1'b1;
        end
    end

    // Build the results: held character, new character, terminator.
    always_comb begin
        run_class_next = run_class_reg;
        held_char_next = held_char_reg;
        res_n          = 2'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            res_unit[i] = TERMINATOR;
            res_eor[i]  = 1'b0;
        end
        if (do_add) begin
            case (run_class_reg)
                RUN_EMPTY: begin
                    held_char_next = add_val;
                    run_class_next = RUN_ONE;
                end
                RUN_ONE: begin
                    res_unit[0]    = held_char_reg;
                    res_unit[1]    = add_val;
                    res_n          = 2'd2;
                    run_class_next = RUN_MANY;
                end
                default: begin
                    res_unit[0]    = add_val;
                    res_n          = 2'd1;
                    run_class_next = RUN_MANY;
                end
            endcase
        end
        if (do_close) begin
            if (run_class_next >= RUN_MANY) begin
                res_unit[res_n] = TERMINATOR;
                res_eor[res_n]  = 1'b1;
                res_n           = res_n + 2'd1;
            end
            run_class_next = RUN_EMPTY;
            held_char_next = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_pending_reg <= 1'b0;
            skipping_reg     <= 1'b0;
            held_char_reg    <= 16'd0;
            run_class_reg    <= RUN_EMPTY;
            out_cnt_reg      <= 2'd0;
        end else begin
            if (q_pop) begin
                lead_pending_reg <= lead_pending_next;
                skipping_reg     <= skipping_next;
                held_char_reg    <= held_char_next;
                run_class_reg    <= run_class_next;
                out_cnt_reg      <= res_n;
            end else if (out_acc) begin
                out_cnt_reg <= out_cnt_reg - 2'd1;
            end
        end
        // Result payload: load on a new byte, shift down on each beat sent.
        if (q_pop) begin
            for (int i = 0; i < MAX_RES; i++) begin
                out_unit_reg[i] <= res_unit[i];
                out_eor_reg[i]  <= res_eor[i];
            end
        end else if (out_acc) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                out_unit_reg[i] <= out_unit_reg[i+1];
                out_eor_reg[i]  <= out_eor_reg[i+1];
            end
        end
    end

endmodule

// ===== rtl/eucjp_text_run_extractor_top.sv =====
// Path: an accepted data byte is registered in the table read stage, then queued;
// the back takes it from the queue head and registers its results in the result buffer.
// Throughput: one input beat per cycle while the queue has room; a byte with several results
// holds the back until its last one is sent, through the single result port behind a four-deep queue.
// Reset: synchronous, active low; clears the run state, queue and result buffer.
// The translation table is not cleared and must be loaded before data arrives.
module eucjp_text_run_extractor_top import ejtre_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_data,
    input  logic [14:0] s_table_index,
    input  logic [15:0] s_table_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_end_of_run,
    output logic        m_last
);

    fifo_cnt_t    q_count;
    logic         q_push;
    ejtre_entry_t q_push_entry;
    logic         q_pop;
    logic         q_valid;
    ejtre_entry_t q_head_entry;

    // Front: table writes, pair lookup.
    ejtre_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_entry       (q_push_entry)
    );

    // Queue between front and back.
    ejtre_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head_entry),
        .count      (q_count)
    );

    // Back: run tracking and result beats.
    ejtre_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_entry      (q_head_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_unit  (m_code_unit),
        .m_end_of_run (m_end_of_run),
        .m_last       (m_last)
    );

    // The queue never receives a beat while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_count < fifo_cnt_t'(FIFO_DEPTH)))
        else $error("queue overflow");

    // Every accepted data byte enters the queue in the following cycle.
    a_data_to_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == MODE_DATA)) |=> q_push)
        else $error("data beat lost before queue");

    // A terminator carries the terminator code and closes the byte's results.
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_run) |-> ((m_code_unit == TERMINATOR) && m_last))
        else $error("malformed terminator beat");

    // The back never takes from an empty queue.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_count != '0))
        else $error("pop from empty queue");

endmodule

// ===== dv/eucjp_run_checker.sv =====
module eucjp_run_checker import ejtre_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_data,
    input  logic [14:0] s_table_index,
    input  logic [15:0] s_table_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_code_unit,
    input  logic        m_end_of_run,
    input  logic        m_last,
    output int          error_count,
    output int          pending_count
);

    // One expected result beat.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        end_of_run;
        logic        last;
    } unit_beat_t;

    // Shadow copy of the translation table and the scanner state.
    logic [15:0] char_map [TABLE_DEPTH];
    logic        lead_pending;
    logic [7:0]  lead_byte;
    logic        skipping;
    logic [15:0] held_char;
    logic [1:0]  run_cls;

    unit_beat_t  expected_units[$];
    unit_beat_t  step_units[$];
    int          mismatches;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            char_map[i] = '0;
        end
        mismatches   = 0;
        lead_pending = 1'b0;
        lead_byte    = '0;
        skipping     = 1'b0;
        held_char    = '0;
        run_cls      = RUN_EMPTY;
    end

    // Character for a two-byte code, or zero when the pair does not translate.
    function automatic logic [15:0] pair_char(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0]       code;
        logic [ADDR_W-1:0] slot;
        code = {hi, lo};
        if ((code & CODE_HIGH_BITS) != CODE_HIGH_BITS) return '0;
        if (code < CODE_LOW_LIMIT || code >= CODE_HIGH_LIMIT) return '0;
        if (code - CODE_BASE >= TABLE_DEPTH_W) return '0;
        slot = ADDR_W'(code - CODE_BASE);
        return char_map[slot];
    endfunction

    // The first character of a run waits until a second one shows up.
    function automatic void append_char(input logic [15:0] ch);
        if (run_cls == RUN_EMPTY) begin
            held_char = ch;
            run_cls   = RUN_ONE;
        end else if (run_cls == RUN_ONE) begin
            step_units.insert(step_units.size(), {held_char, 1'b0, 1'b0});
            step_units.insert(step_units.size(), {ch, 1'b0, 1'b0});
            run_cls = RUN_MANY;
        end else begin
            step_units.insert(step_units.size(), {ch, 1'b0, 1'b0});
            run_cls = RUN_MANY;
        end
    endfunction

    // Only a run that was actually emitted gets a terminator.
    function automatic void close_run();
        if (run_cls >= RUN_MANY) begin
            step_units.insert(step_units.size(), {TERMINATOR, 1'b1, 1'b0});
        end
        run_cls   = RUN_EMPTY;
        held_char = '0;
    endfunction

    // Advances the shadow state by one input beat and queues its code units.
    function automatic void predict_code_units(input logic mode, input logic [7:0] b,
                                               input logic eod, input logic [14:0] idx,
                                               input logic [15:0] val);
        logic [15:0] ch;
        unit_beat_t  u;
        step_units.delete();
        if (mode == MODE_TABLE) begin
            if (int'(idx) < TABLE_DEPTH) begin
                char_map[idx] = val;
            end
            return;
        end

        if (lead_pending) begin
            ch           = pair_char(lead_byte, b);
            lead_pending = 1'b0;
            if (ch != 16'h0000) begin
                append_char(ch);
            end else begin
                // A bad pair flushes the run; its second byte already belongs to the skip.
                close_run();
                skipping = (b != 8'h00);
            end
        end else if (skipping) begin
            if (b == 8'h00) begin
                skipping = 1'b0;
                close_run();
            end
        end else if (b < PRINT_LOW) begin
            close_run();
        end else if (b < PRINT_END) begin
            append_char({8'h00, b});
        end else begin
            lead_pending = 1'b1;
            lead_byte    = b;
        end

        // End of data drops a pending lead, ends a skip and flushes the run.
        if (eod) begin
            lead_pending = 1'b0;
            skipping     = 1'b0;
            close_run();
        end

        for (int k = 0; k < step_units.size(); k++) begin
            u      = step_units[k];
            u.last = (k == step_units.size() - 1);
            expected_units.insert(expected_units.size(), u);
        end
    endfunction

    // Watch both channels: input beats feed the prediction, result beats are compared.
    always @(posedge aclk) begin : monitor
        unit_beat_t want;
        if (!aresetn) begin
            lead_pending = 1'b0;
            lead_byte    = '0;
            skipping     = 1'b0;
            held_char    = '0;
            run_cls      = RUN_EMPTY;
        end else begin
            if (s_valid && s_ready) begin
                predict_code_units(s_mode, s_data_byte, s_end_of_data,
                                   s_table_index, s_table_value);
            end
            if (m_valid && m_ready) begin
                if (expected_units.size() == 0) begin
                    $error("unexpected result beat: code_unit %h end_of_run %b last %b",
                           m_code_unit, m_end_of_run, m_last);
                    mismatches++;
                end else begin
                    want = expected_units.pop_front();
                    if (m_code_unit !== want.code_unit) begin
                        $error("code_unit: expected %h, actual %h",
                               want.code_unit, m_code_unit);
                        mismatches++;
                    end
                    if (m_end_of_run !== want.end_of_run) begin
                        $error("end_of_run: expected %b, actual %b",
                               want.end_of_run, m_end_of_run);
                        mismatches++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %b, actual %b", want.last, m_last);
                        mismatches++;
                    end
                end
            end
        end
        error_count   <= mismatches;
        pending_count <= expected_units.size();
    end

endmodule

// ===== dv/tb_eucjp_text_run_extractor_top.sv =====
module tb_eucjp_text_run_extractor_top;
    import ejtre_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 70;

    // Every byte of 0x80 and above in the random stimulus comes from this set, so each
    // code that it can look up is loaded before data arrives.
    localparam logic [7:0] HIGH_BYTES [6] = '{8'h80, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hFF};

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic        s_mode        = MODE_DATA;
    logic [7:0]  s_data_byte   = '0;
    logic        s_end_of_data = 1'b0;
    logic [14:0] s_table_index = '0;
    logic [15:0] s_table_value = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [15:0] m_code_unit;
    logic        m_end_of_run;
    logic        m_last;

    int   errors_seen;
    int   units_pending;
    int   idle_pct    = 0;
    int   stall_pct   = 0;
    int   item_count  = 0;
    int   cycle_count = 0;
    int   hold_left   = 0;
    logic hold_req    = 1'b0;
    logic hold_ack    = 1'b0;

    eucjp_text_run_extractor_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_end_of_run  (m_end_of_run),
        .m_last        (m_last)
    );

    eucjp_run_checker run_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_data_byte   (s_data_byte),
        .s_end_of_data (s_end_of_data),
        .s_table_index (s_table_index),
        .s_table_value (s_table_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_end_of_run  (m_end_of_run),
        .m_last        (m_last),
        .error_count   (errors_seen),
        .pending_count (units_pending)
    );

    always #5 aclk = ~aclk;

    // Give up if the run never drains.
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when requested.
    always @(negedge aclk) begin : result_sink
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // A byte of 0x80 or above from the loaded set.
    function automatic logic [7:0] high_byte();
        return HIGH_BYTES[3'($urandom_range(5))];
    endfunction

    // Any byte, high ones restricted to the loaded set.
    function automatic logic [7:0] any_byte();
        if ($urandom_range(1) == 1) begin
            return high_byte();
        end
        return 8'($urandom_range(8'h7F));
    endfunction

    function automatic logic [7:0] nonzero_byte();
        logic [7:0] b;
        b = any_byte();
        return (b == 8'h00) ? 8'h01 : b;
    endfunction

    // Offers one beat, idling first at random; returns at the falling edge after acceptance.
    task automatic send_beat(input logic mode, input logic [7:0] b, input logic eod,
                             input logic [14:0] idx, input logic [15:0] val);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_data_byte   <= b;
        s_end_of_data <= eod;
        s_table_index <= idx;
        s_table_value <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        item_count++;
    endtask

    // Unused payload fields carry random values so the block must ignore them.
    task automatic send_data(input logic [7:0] b, input logic eod);
        send_beat(MODE_DATA, b, eod, 15'($urandom_range(32767)), 16'($urandom_range(65535)));
    endtask

    task automatic send_table(input logic [14:0] idx, input logic [15:0] val);
        send_beat(MODE_TABLE, 8'($urandom_range(255)), 1'($urandom_range(1)), idx, val);
    endtask

    // One character: printable ASCII or a well-formed two-byte pair.
    task automatic send_text_char();
        if ($urandom_range(1) == 1) begin
            send_data(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
        end else begin
            send_data(8'($urandom_range(8'hA4, 8'hA1)), 1'b0);
            send_data(8'($urandom_range(8'hA4, 8'hA1)), 1'b0);
        end
    endtask

    // Random traffic: mostly text runs, with broken pairs, table updates and noise.
    task automatic run_phase(input int n_items);
        int stop_at;
        int kind;
        int pick;
        int len;
        stop_at = item_count + n_items;
        while (item_count < stop_at) begin
            kind = int'($urandom_range(99));
            if (kind < 55) begin
                len = int'($urandom_range(6));
                repeat (len) send_text_char();
                pick = int'($urandom_range(9));
                if (pick < 6) begin
                    send_data(8'($urandom_range(8'h1F)), 1'b0);
                end else if (pick < 8) begin
                    send_data(8'($urandom_range(8'h7E, 8'h20)), 1'b1);
                end else if (pick == 8) begin
                    send_data(high_byte(), 1'b1);
                end
            end else if (kind < 70) begin
                // A pair whose second byte lacks its high bit, then a skip.
                send_data(high_byte(), 1'b0);
                send_data(8'($urandom_range(8'h7F)), 1'b0);
                len = int'($urandom_range(4));
                repeat (len) send_data(nonzero_byte(), 1'b0);
                if ($urandom_range(9) < 7) begin
                    send_data(8'h00, 1'b0);
                end else begin
                    send_data(any_byte(), 1'b1);
                end
            end else if (kind < 80) begin
                send_table(15'($urandom_range(32767)),
                           ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom_range(65535, 1)));
            end else begin
                len = int'($urandom_range(4, 1));
                repeat (len) send_data(any_byte(), 1'($urandom_range(7) == 0));
            end
        end
    endtask

    initial begin : stimulus
        logic [15:0] code;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Load every entry the stimulus can look up; some entries stay unassigned.
        for (int lead_i = 0; lead_i < 4; lead_i++) begin
            for (int trail_i = 0; trail_i < 6; trail_i++) begin
                code = {8'(8'hA1 + lead_i), HIGH_BYTES[3'(trail_i)]};
                send_table(15'(code - CODE_BASE),
                           ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom_range(65535, 1)));
            end
        end

        // Directed: table extremes, including writes past the end that must be ignored.
        send_table(15'h0021, 16'h3000);
        send_table(15'h5D7F, 16'hFFFF);
        send_table(15'h0100, 16'h0000);
        send_table(15'(TABLE_DEPTH), 16'h1234);
        send_beat(MODE_TABLE, 8'h41, 1'b1, 15'h7FFF, 16'hBEEF);
        // Printable extremes closed by a zero control byte.
        send_data(8'h20, 1'b0);
        send_data(8'h7E, 1'b0);
        send_data(8'h00, 1'b0);
        // Lowest and highest translatable codes.
        send_data(8'hA1, 1'b0);
        send_data(8'hA1, 1'b0);
        send_data(8'hFE, 1'b0);
        send_data(8'hFF, 1'b0);
        // Unassigned entry: flush, then a skip ended by a zero byte.
        send_data(8'hA2, 1'b0);
        send_data(8'h80, 1'b0);
        send_data(8'h41, 1'b0);
        send_data(8'h00, 1'b0);
        // Bad pair whose second byte is zero ends the skip at once.
        send_data(8'h80, 1'b0);
        send_data(8'h00, 1'b0);
        // A lone character is dropped.
        send_data(8'h41, 1'b0);
        send_data(8'h1F, 1'b0);
        // Bad pair format, then end of data while skipping.
        send_data(8'h7F, 1'b0);
        send_data(8'h41, 1'b0);
        send_data(8'hFF, 1'b1);
        // End of data on the second character gives three results.
        send_data(8'h41, 1'b0);
        send_data(8'h42, 1'b1);
        // Table write inside a run, then a lead byte dropped at end of data.
        send_data(8'h78, 1'b0);
        send_table(15'h0021, 16'h3001);
        send_data(8'h79, 1'b0);
        send_data(8'hB0, 1'b1);

        // No idling, starting under a long result hold-off.
        hold_req = ~hold_req;
        run_phase(PHASE_ITEMS);

        idle_pct = 83;
        run_phase(PHASE_ITEMS);

        idle_pct  = 0;
        stall_pct = 83;
        run_phase(PHASE_ITEMS);

        idle_pct  = 28;
        stall_pct = 28;
        run_phase(PHASE_ITEMS);

        // Drain and let any stray result show up.
        s_valid   <= 1'b0;
        stall_pct = 0;
        while (units_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (errors_seen == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
